>>> rtl/core/msrs_pkg.sv
package msrs_pkg;

   // Mersenne modulus of the minimal-standard generator, 2^31 - 1
   localparam logic [30:0] LCG_MOD = 31'h7FFF_FFFF;

   // Step strobes from the sequencer to the datapath
   typedef struct packed {
      logic load;    // request taken: latch fields, start generator multiply
      logic fold;    // reduce product mod 2^31-1, commit new state
      logic prep;    // first product (uniform) or span/multiplier select (broken stick)
      logic mul_a;   // second product stage
      logic mul_b;   // third product stage / partial-product merge
      logic fin;     // final add, saturate, load output register
   } msrs_cmd_type;

endpackage

>>> rtl/core/msrs_datapath.sv
module msrs_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  msrs_pkg::msrs_cmd_type cmd,
   input  logic                 csr_wr_en,
   input  logic [30:0]          csr_wr_data,
   input  logic                 req_opcode,
   input  logic signed [31:0]   req_mean,
   input  logic [15:0]          req_coeff_variation,
   input  logic signed [31:0]   req_low_bound,
   input  logic signed [31:0]   req_high_bound,
   output logic signed [31:0]   rsp_sample,
   output logic [30:0]          rsp_raw_random
);
   import msrs_pkg::*;

   localparam logic [14:0] LCG_MUL   = 15'd16807;
   localparam logic [30:0] SQRT3_Q30 = 31'h6ED9_EBA1;   // sqrt(3) in Q2.30

   // generator
   logic [30:0]        gen_ff, gen_in;
   logic [30:0]        seed_state;
   logic [45:0]        prod_ff, prod_in;
   logic [31:0]        fold_sum;
   logic [30:0]        x_ff, x_in;

   // latched request
   logic               op_ff;
   logic signed [31:0] mean_ff, lo_ff, hi_ff;
   logic [15:0]        cv_ff;

   // working registers
   logic signed [35:0] span_ff, span_in;
   logic [30:0]        mult_ff, mult_in;
   logic signed [31:0] base_ff, base_in;
   logic signed [66:0] acc_ff, acc_in;
   logic [47:0]        pb_ff, pb_in;
   logic signed [31:0] sample_ff, sample_in;
   logic [30:0]        raw_ff;

   // ---------------- generator ----------------
   assign seed_state = (csr_wr_data == '0 || csr_wr_data == LCG_MOD) ? 31'd1 : csr_wr_data;
   assign prod_in    = 46'(gen_ff) * 46'(LCG_MUL);

   // p mod (2^31-1) = hi + lo, one conditional subtract
   assign fold_sum = 32'(prod_ff[45:31]) + {1'b0, prod_ff[30:0]};
   assign x_in     = (fold_sum >= {1'b0, LCG_MOD}) ? 31'(fold_sum - {1'b0, LCG_MOD})
                                                   : fold_sum[30:0];

   always_comb begin
      gen_in = gen_ff;
      if (csr_wr_en) begin
         gen_in = seed_state;
      end else if (cmd.fold) begin
         gen_in = x_in;
      end
   end

   // ---------------- prep ----------------
   logic signed [31:0] d_q31;
   logic signed [48:0] p1;
   logic signed [35:0] mean36, lo36, hi36, span_lo, span_hi;
   logic               low_half;

   // d = 2x - 2^31 as signed Q0.31
   assign d_q31 = $signed({~x_ff[30], x_ff[29:0], 1'b0});
   assign p1    = 49'($signed({1'b0, cv_ff})) * 49'(d_q31);

   assign mean36  = 36'(mean_ff);
   assign lo36    = 36'(lo_ff);
   assign hi36    = 36'(hi_ff);
   // twice the median minus twice the nearer limit
   assign span_lo = (mean36 <<< 2) - lo36 - (lo36 <<< 1) - hi36;
   assign span_hi = (mean36 <<< 2) - lo36 - hi36 - (hi36 <<< 1);
   assign low_half = !x_ff[30] || (x_ff[29:0] == '0);

   assign span_in = low_half ? span_lo : span_hi;
   assign mult_in = low_half ? x_ff : 31'(32'h8000_0000 - {1'b0, x_ff});
   assign base_in = op_ff ? (low_half ? lo_ff : hi_ff) : mean_ff;

   // ---------------- product stages ----------------
   logic signed [31:0] f1, f2;
   logic signed [63:0] p2, p3;
   logic signed [19:0] span_hi20;
   logic signed [50:0] pa;

   assign f1 = $signed(acc_ff[47:16]);
   assign p2 = 64'(f1) * 64'($signed({1'b0, SQRT3_Q30}));
   assign f2 = $signed(acc_ff[62:31]);
   assign p3 = 64'(mean_ff) * 64'(f2);

   // broken stick: span split into signed high and unsigned low halves
   assign span_hi20 = $signed(span_ff[35:16]);
   assign pa        = 51'(span_hi20) * 51'($signed({1'b0, mult_ff}));
   assign pb_in     = 48'(span_ff[15:0]) * 48'(mult_ff) + 48'd1073741824;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.prep) begin
         acc_in = 67'(p1) + 67'sd32768;
      end else if (cmd.mul_a) begin
         acc_in = op_ff ? 67'(pa) : 67'(p2) + 67'sd1073741824;
      end else if (cmd.mul_b) begin
         acc_in = op_ff ? (acc_ff <<< 16) + $signed({19'd0, pb_ff})
                        : 67'(p3) + 67'sd536870912;
      end
   end

   // ---------------- final add and saturate ----------------
   logic signed [36:0] q37, res37;

   assign q37   = op_ff ? 37'($signed(acc_ff[66:31])) : 37'($signed(acc_ff[63:30]));
   assign res37 = 37'(base_ff) + q37;

   always_comb begin
      if (res37[36:31] != {6{res37[31]}}) begin
         sample_in = res37[36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sample_in = res37[31:0];
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= 31'd1;
      end else begin
         gen_ff <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         prod_ff <= prod_in;
         op_ff   <= req_opcode;
         mean_ff <= req_mean;
         cv_ff   <= req_coeff_variation;
         lo_ff   <= req_low_bound;
         hi_ff   <= req_high_bound;
      end
      if (cmd.fold) begin
         x_ff <= x_in;
      end
      if (cmd.prep) begin
         span_ff <= span_in;
         mult_ff <= mult_in;
         base_ff <= base_in;
      end
      if (cmd.mul_a) begin
         pb_ff <= pb_in;
      end
      acc_ff <= acc_in;
      if (cmd.fin) begin
         sample_ff <= sample_in;
         raw_ff    <= x_ff;
      end
   end

   assign rsp_sample     = sample_ff;
   assign rsp_raw_random = raw_ff;

endmodule

>>> rtl/core/msrs_ctrl.sv
module msrs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output msrs_pkg::msrs_cmd_type cmd
);
   import msrs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_PREP,
      ST_MUL_A,
      ST_MUL_B,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free, accept, finish;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == ST_FIN) && out_free;
   // next request may enter as the current result lands in the output register
   assign req_ready = (state_ff == ST_IDLE) || finish;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_FOLD;
         ST_FOLD:  state_in = ST_PREP;
         ST_PREP:  state_in = ST_MUL_A;
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_FIN;
         ST_FIN: begin
            if (out_free) begin
               state_in = accept ? ST_FOLD : ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd       = '0;
      cmd.load  = accept;
      cmd.fold  = (state_ff == ST_FOLD);
      cmd.prep  = (state_ff == ST_PREP);
      cmd.mul_a = (state_ff == ST_MUL_A);
      cmd.mul_b = (state_ff == ST_MUL_B);
      cmd.fin   = finish;
   end

endmodule

>>> rtl/core/minimal_standard_rng_sampler_top.sv
// Minimal-standard random sampler.
// Request channel (req_valid/req_ready) carries opcode, mean, coefficient of
// variation and the broken-stick limits; each request advances the 31-bit
// generator once and yields one response (rsp_valid/rsp_ready) with the
// saturated Q16.16 sample and the new generator state.
// A request passes through generator reduction, three dependent multiply
// stages and the final add/saturate; the block takes no new request until the
// current one finishes.
// The response sits in an output register; the next request is taken in the
// same cycle the finished result is loaded, so a waiting response does not
// hold off the next request. If the receiver stalls with a response pending,
// the finished item waits in its last stage and req_ready stays low.
// csr_wr_en loads the generator from csr_wr_data (0 and 2^31-1 load 1);
// write only while no request is in flight.
// Reset (synchronous) empties the pipeline and sets the generator state to 1.
module minimal_standard_rng_sampler_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [30:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic signed [31:0] req_mean,
   input  logic [15:0]        req_coeff_variation,
   input  logic signed [31:0] req_low_bound,
   input  logic signed [31:0] req_high_bound,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_sample,
   output logic [30:0]        rsp_raw_random
);
   import msrs_pkg::*;

   msrs_cmd_type cmd;

   msrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   msrs_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_opcode          (req_opcode),
      .req_mean            (req_mean),
      .req_coeff_variation (req_coeff_variation),
      .req_low_bound       (req_low_bound),
      .req_high_bound      (req_high_bound),
      .rsp_sample          (rsp_sample),
      .rsp_raw_random      (rsp_raw_random)
   );

endmodule

>>> rtl/core/msrs_checker.sv
module msrs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_sample,
   input logic [30:0]        rsp_raw_random
);
   import msrs_pkg::*;

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample)
                                  && $stable(rsp_raw_random))
      else $error("response changed while stalled");

   // generator never reaches a locked value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_raw_random != '0 && rsp_raw_random != LCG_MOD)
      else $error("generator state out of range");

   // a request occupies the datapath, so requests are never taken back to back
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken back to back");

   // reset leaves an empty, ready block
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind minimal_standard_rng_sampler_top msrs_checker u_msrs_checker (.*);

>>> test/tb_minimal_standard_rng_sampler_top.sv
module tb_minimal_standard_rng_sampler_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef longint unsigned u64_type;

   typedef struct {
      bit        opcode;
      int        mean;
      bit [15:0] cv;
      int        low_bound;
      int        high_bound;
   } sample_req_type;

   typedef struct {
      int        sample;
      bit [30:0] raw_random;
   } sample_rsp_type;

   localparam bit        OP_UNIFORM      = 1'b0;
   localparam bit        OP_BROKEN_STICK = 1'b1;
   localparam int        INT_MAX         = 32'sh7FFF_FFFF;
   localparam int        INT_MIN         = 32'sh8000_0000;
   localparam bit [15:0] CV_TOP          = 16'd37837;
   localparam bit [30:0] SEED_MERSENNE   = 31'h7FFF_FFFF;
   // 16807 * this seed mod (2^31-1) is exactly 2^30: first draw hits the midpoint
   localparam bit [30:0] SEED_MIDPOINT   = 31'd703838500;

   class sample_scoreboard;
      bit [30:0]      gen_state = 31'd1;
      sample_rsp_type pending_draws[$];
      int             errors = 0;

      function void load_seed(bit [30:0] v);
         gen_state = (v == 31'd0 || v == SEED_MERSENNE) ? 31'd1 : v;
      endfunction

      static function u64_type mag(longint v);
         return v < 0 ? u64_type'(-v) : u64_type'(v);
      endfunction

      // signed value (neg ? -m : m) / 2^s, rounded half toward +inf
      static function longint rnd_shift(bit neg, u64_type m, int s);
         u64_type half;
         half = u64_type'(1) << (s - 1);
         if (!neg)
            return $signed((m + half) >> s);
         if (m <= half)
            return 0;
         return -$signed((m - half + (u64_type'(1) << s) - 1) >> s);
      endfunction

      function void note_request(sample_req_type r);
         u64_type        x;
         longint         d, f1, f2, m2, span, res;
         sample_rsp_type e;
         x = (u64_type'(gen_state) * 64'd16807) % 64'd2147483647;
         gen_state = x[30:0];
         if (r.opcode == OP_UNIFORM) begin
            d = 2 * $signed(x) - 64'sd2147483648;
            f1 = rnd_shift(d < 0, u64_type'(r.cv) * mag(d), 16);
            f2 = rnd_shift(f1 < 0, mag(f1) * 64'd1859775393, 31);
            res = longint'(r.mean)
                  + rnd_shift((r.mean < 0) != (f2 < 0), mag(r.mean) * mag(f2), 30);
         end else begin
            // m2 is twice the median
            m2 = 4 * longint'(r.mean) - longint'(r.low_bound) - longint'(r.high_bound);
            if (x <= 64'd1073741824) begin
               span = m2 - 2 * longint'(r.low_bound);
               res = longint'(r.low_bound) + rnd_shift(span < 0, mag(span) * x, 31);
            end else begin
               span = 2 * longint'(r.high_bound) - m2;
               res = longint'(r.high_bound)
                     + rnd_shift(span > 0, mag(span) * (64'd2147483648 - x), 31);
            end
         end
         if (res > longint'(INT_MAX))
            e.sample = INT_MAX;
         else if (res < longint'(INT_MIN))
            e.sample = INT_MIN;
         else
            e.sample = int'(res);
         e.raw_random = x[30:0];
         pending_draws.push_back(e);
      endfunction

      function void check_response(logic [31:0] sample, logic [30:0] raw);
         sample_rsp_type e;
         if (pending_draws.size() == 0) begin
            errors++;
            $display("%0t: response with nothing outstanding: sample %h raw %h",
                     $time, sample, raw);
            return;
         end
         e = pending_draws.pop_front();
         if (sample !== e.sample) begin
            errors++;
            $display("%0t: sample expected %h actual %h", $time, e.sample, sample);
         end
         if (raw !== e.raw_random) begin
            errors++;
            $display("%0t: raw_random expected %h actual %h", $time, e.raw_random, raw);
         end
      endfunction

      function int outstanding();
         return pending_draws.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [30:0]        csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_opcode = 1'b0;
   logic signed [31:0] req_mean = '0;
   logic [15:0]        req_coeff_variation = '0;
   logic signed [31:0] req_low_bound = '0;
   logic signed [31:0] req_high_bound = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_sample;
   logic [30:0]        rsp_raw_random;

   bit                 calm = 1'b0;
   sample_scoreboard   sb = new();

   minimal_standard_rng_sampler_top dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_mean            (req_mean),
      .req_coeff_variation (req_coeff_variation),
      .req_low_bound       (req_low_bound),
      .req_high_bound      (req_high_bound),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sample          (rsp_sample),
      .rsp_raw_random      (rsp_raw_random)
   );

   always #6 clock = ~clock;

   function automatic sample_req_type req_of(bit op, int mean, bit [15:0] cv, int lo, int hi);
      sample_req_type r;
      r.opcode = op;
      r.mean = mean;
      r.cv = cv;
      r.low_bound = lo;
      r.high_bound = hi;
      return r;
   endfunction

   function automatic int extreme_value();
      case ($urandom_range(4))
         0: return INT_MIN;
         1: return INT_MAX;
         2: return 0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   function automatic sample_req_type random_req();
      sample_req_type r;
      int             kind;
      int             spread;
      int             tmp;
      kind = $urandom_range(99);
      r.opcode = 1'($urandom_range(1));
      if (kind < 60) begin
         // sensible parameters: low <= mean <= high, cv within range
         r.mean = $signed($urandom) >>> $urandom_range(1, 14);
         r.cv = 16'($urandom_range(CV_TOP));
         spread = $urandom >> $urandom_range(4, 31);
         r.low_bound = r.mean - int'($urandom_range(spread));
         r.high_bound = r.mean + int'($urandom_range(spread));
      end else if (kind < 80) begin
         r.mean = $urandom;
         r.cv = 16'($urandom);
         r.low_bound = $urandom;
         r.high_bound = $urandom;
      end else if (kind < 90) begin
         r.mean = extreme_value();
         r.low_bound = extreme_value();
         r.high_bound = extreme_value();
         case ($urandom_range(3))
            0: r.cv = '0;
            1: r.cv = CV_TOP;
            2: r.cv = 16'hFFFF;
            default: r.cv = 16'($urandom);
         endcase
      end else begin
         // limits swapped
         r.mean = $urandom;
         r.cv = 16'($urandom_range(CV_TOP));
         r.low_bound = $urandom;
         r.high_bound = $urandom;
         if (r.low_bound < r.high_bound) begin
            tmp = r.low_bound;
            r.low_bound = r.high_bound;
            r.high_bound = tmp;
         end
      end
      return r;
   endfunction

   task automatic send_req(sample_req_type r);
      while (!calm && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= r.opcode;
      req_mean <= r.mean;
      req_coeff_variation <= r.cv;
      req_low_bound <= r.low_bound;
      req_high_bound <= r.high_bound;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic write_seed(bit [30:0] v);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.load_seed(v);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_response(rsp_sample, rsp_raw_random);
         rsp_ready <= calm || ($urandom_range(99) >= 32);
      end
   end

   initial begin
      bit [30:0] seed_value;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // generator still at its reset state
      send_req(req_of(OP_UNIFORM, INT_MAX, CV_TOP, 0, 0));
      send_req(req_of(OP_UNIFORM, INT_MIN, CV_TOP, -1, -1));
      send_req(req_of(OP_UNIFORM, 0, 16'hFFFF, INT_MAX, INT_MIN));
      send_req(req_of(OP_UNIFORM, 65536, 16'd0, 0, 0));
      send_req(req_of(OP_UNIFORM, INT_MAX, 16'hFFFF, 0, 0));
      send_req(req_of(OP_UNIFORM, INT_MIN, 16'hFFFF, 0, 0));
      send_req(req_of(OP_UNIFORM, -65536, 16'd1, 0, 0));
      send_req(req_of(OP_UNIFORM, 123456789, 16'd20000, 0, 0));
      send_req(req_of(OP_BROKEN_STICK, 0, 16'd0, INT_MIN, INT_MAX));
      send_req(req_of(OP_BROKEN_STICK, 327680, 16'd0, 0, 655360));
      send_req(req_of(OP_BROKEN_STICK, -196608, 16'd0, -655360, 131072));
      send_req(req_of(OP_BROKEN_STICK, 0, 16'd0, 655360, -655360));
      send_req(req_of(OP_BROKEN_STICK, INT_MAX, 16'd0, INT_MIN, INT_MIN));
      send_req(req_of(OP_BROKEN_STICK, INT_MIN, 16'hFFFF, INT_MAX, INT_MAX));
      send_req(req_of(OP_BROKEN_STICK, 65536, 16'd0, 65536, 65536));
      send_req(req_of(OP_BROKEN_STICK, 1310720, CV_TOP, 0, 65536));
      // draw exactly at the midpoint: boundary of the broken-stick split, zero offset
      write_seed(SEED_MIDPOINT);
      send_req(req_of(OP_BROKEN_STICK, 327680, 16'd0, 0, 655360));
      write_seed(SEED_MIDPOINT);
      send_req(req_of(OP_UNIFORM, 65536, CV_TOP, 0, 0));

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: seed_value = 31'h7FFF_FFFE;
            1: seed_value = 31'd0;
            2: seed_value = SEED_MERSENNE;
            3: seed_value = 31'd1;
            default: seed_value = 31'($urandom);
         endcase
         calm = (p == 4);
         write_seed(seed_value);
         repeat (212) send_req(random_req());
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("%0t: timeout", $time);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/msrs_pkg.sv
rtl/core/msrs_datapath.sv
rtl/core/msrs_ctrl.sv
rtl/core/minimal_standard_rng_sampler_top.sv
rtl/core/msrs_checker.sv
test/tb_minimal_standard_rng_sampler_top.sv
